>>> rtl/bitmap_value_pool_allocator_unit_defines.svh
// Assertion macros used by the allocator RTL.
`ifndef BITMAP_VALUE_POOL_ALLOCATOR_UNIT_DEFINES_SVH
`define BITMAP_VALUE_POOL_ALLOCATOR_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define BVPA_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define BVPA_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/bvpa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bvpa_pkg;

   localparam int POOL_SIZE_DEF = 4096;
   localparam int WORD_BITS_DEF = 32;

   localparam int VALUE_W   = 32;
   localparam int COUNT_W   = 13;
   localparam int FUNC_W    = 2;
   localparam int CSR_IDX_W = 2;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_ALLOC   = 2'd0,
      FUNC_RESERVE = 2'd1,
      FUNC_RELEASE = 2'd2
   } func_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BASE_VALUE = 2'd0,
      CSR_POOL_COUNT = 2'd1,
      CSR_IN_ORDER   = 2'd2
   } csr_index_type;

endpackage

`default_nettype wire

>>> rtl/bvpa_bitmap_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module bvpa_bitmap_ram #(
   parameter int DEPTH    = (bvpa_pkg::POOL_SIZE_DEF + bvpa_pkg::WORD_BITS_DEF - 1)
                            / bvpa_pkg::WORD_BITS_DEF,
   parameter int WIDTH    = bvpa_pkg::WORD_BITS_DEF,
   localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);
   import bvpa_pkg::*;

   logic [WIDTH-1:0] bitmap_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         bitmap_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= bitmap_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> rtl/bvpa_word_scan.sv
`timescale 1ns / 1ps
`default_nettype none

module bvpa_word_scan #(
   parameter int POOL_SIZE = bvpa_pkg::POOL_SIZE_DEF,
   parameter int WORD_BITS = bvpa_pkg::WORD_BITS_DEF,
   localparam int SUM_W    = $clog2(POOL_SIZE + WORD_BITS + 1),
   localparam int BIT_W    = $clog2(WORD_BITS)
) (
   input  wire logic [WORD_BITS-1:0] word_data,
   input  wire logic [SUM_W-1:0]     word_pos,
   input  wire logic [SUM_W-1:0]     lo_pos,
   input  wire logic [SUM_W-1:0]     hi_pos,
   output logic                      hit,
   output logic      [BIT_W-1:0]     hit_bit,
   output logic                      last_word
);
   import bvpa_pkg::*;

   logic [WORD_BITS-1:0] free_bits;

   // Mark a bit free when clear and inside the window [lo_pos, hi_pos).
   for (genvar g = 0; g < WORD_BITS; g++) begin : g_bit
      logic [SUM_W-1:0] bit_pos;
      assign bit_pos      = word_pos + SUM_W'(g);
      assign free_bits[g] = !word_data[g] && (bit_pos >= lo_pos) && (bit_pos < hi_pos);
   end

   // Pick the lowest free bit.
   always_comb begin
      hit     = 1'b0;
      hit_bit = '0;
      for (int b = WORD_BITS - 1; b >= 0; b--) begin
         if (free_bits[b]) begin
            hit     = 1'b1;
            hit_bit = BIT_W'(b);
         end
      end
   end

   assign last_word = (word_pos + SUM_W'(WORD_BITS)) >= hi_pos;

endmodule

`default_nettype wire

>>> rtl/bitmap_value_pool_allocator_unit.sv
// Reserve, release: divide, issue, modify, then finish; a range miss, an unknown function or an
// allocate from an empty pool goes straight to finish. Allocate: divide, issue, then a scan of
// 1 .. POOL_SIZE/WORD_BITS + 1 bitmap words, one word per cycle from the RAM's read port, then
// finish, which waits for a free output register. One request is in flight at a time; the next
// is taken once the result is registered. Reset: synchronous, active high; a clearing pass zeroes
// the bitmap and holds req_tready low meanwhile. Registers reset to base 0, count POOL_SIZE, next-fit.
`timescale 1ns / 1ps
`default_nettype none

`include "bitmap_value_pool_allocator_unit_defines.svh"

module bitmap_value_pool_allocator_unit #(
   parameter int POOL_SIZE = bvpa_pkg::POOL_SIZE_DEF,
   parameter int WORD_BITS = bvpa_pkg::WORD_BITS_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   // request channel
   input  wire logic                           req_tvalid,
   output logic                                req_tready,
   input  wire logic [bvpa_pkg::VALUE_W-1:0]   req_tdata,  // [31:0] req_value
   input  wire logic [bvpa_pkg::FUNC_W-1:0]    req_tuser,  // [1:0] func
   // response channel
   output logic                                rsp_tvalid,
   input  wire logic                           rsp_tready,
   output logic [47:0]                         rsp_tdata,  // [31:0] out_value, [44:32] lease_count
   output logic                                rsp_tuser,  // [0] status
   // configuration write channel
   input  wire logic                           csr_valid,
   output logic                                csr_ready,
   input  wire logic [bvpa_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [bvpa_pkg::VALUE_W-1:0]   csr_data
);
   import bvpa_pkg::*;

   localparam int NWORDS  = (POOL_SIZE + WORD_BITS - 1) / WORD_BITS;
   localparam int ADDR_W  = (NWORDS > 1) ? $clog2(NWORDS) : 1;
   localparam int POS_W   = $clog2(POOL_SIZE);
   localparam int CNT_W   = $clog2(POOL_SIZE + 1);
   localparam int SUM_W   = $clog2(POOL_SIZE + WORD_BITS + 1);
   localparam int BIT_W   = $clog2(WORD_BITS);
   // Word index = pos / WORD_BITS as a multiply by a rounded-up reciprocal, exact for pos < 2^POS_W.
   localparam int DIV_S   = POS_W + BIT_W;
   localparam int RECIP_W = POS_W + 2;
   localparam longint RECIP = ((64'd1 << DIV_S) + WORD_BITS - 1) / WORD_BITS;
   localparam int PAD_W   = 48 - VALUE_W - COUNT_W;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DIVIDE,
      ST_ISSUE,
      ST_SCAN,
      ST_MODIFY,
      ST_FINISH
   } state_type;

   state_type state_ff, state_in;

   logic [VALUE_W-1:0] base_ff, base_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               in_order_ff, in_order_in;

   logic [POS_W-1:0]   next_pos_ff, next_pos_in;
   logic [CNT_W-1:0]   leases_ff, leases_in;
   logic [ADDR_W-1:0]  clr_addr_ff, clr_addr_in;

   logic [FUNC_W-1:0]  func_ff, func_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [POS_W-1:0]   quot_ff, quot_in;
   logic [ADDR_W-1:0]  word_ff, word_in;
   logic [SUM_W-1:0]   wpos_ff, wpos_in;
   logic [BIT_W-1:0]   off_ff, off_in;
   logic [SUM_W-1:0]   lo_ff, lo_in;
   logic [SUM_W-1:0]   hi_ff, hi_in;
   logic               wrap_ff, wrap_in;

   logic               res_status_ff, res_status_in;
   logic [VALUE_W-1:0] res_value_ff, res_value_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_status_ff, rsp_status_in;
   logic [VALUE_W-1:0] rsp_value_ff, rsp_value_in;
   logic [COUNT_W-1:0] rsp_lease_ff, rsp_lease_in;

   // bitmap RAM and word scanner
   logic                 ram_wr_en;
   logic [ADDR_W-1:0]    ram_wr_addr;
   logic [WORD_BITS-1:0] ram_wr_data;
   logic [WORD_BITS-1:0] ram_rd_data;

   logic                 scan_hit;
   logic [BIT_W-1:0]     scan_bit;
   logic                 scan_last;

   logic [CNT_W-1:0]         eff_count;
   logic [VALUE_W-1:0]       req_offset;
   logic                     req_in_range;
   logic [POS_W-1:0]         start_pos;
   logic [POS_W+RECIP_W-1:0] div_prod;
   logic [SUM_W-1:0]         word_base;
   logic [SUM_W-1:0]         hit_pos;
   logic [SUM_W-1:0]         hit_next;
   logic [WORD_BITS-1:0]     off_mask;
   logic [WORD_BITS-1:0]     hit_mask;
   logic                     cur_bit;

   bvpa_bitmap_ram #(
      .DEPTH (NWORDS),
      .WIDTH (WORD_BITS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (word_in),
      .rd_data (ram_rd_data)
   );

   bvpa_word_scan #(
      .POOL_SIZE (POOL_SIZE),
      .WORD_BITS (WORD_BITS)
   ) u_scan (
      .word_data (ram_rd_data),
      .word_pos  (wpos_ff),
      .lo_pos    (lo_ff),
      .hi_pos    (hi_ff),
      .hit       (scan_hit),
      .hit_bit   (scan_bit),
      .last_word (scan_last)
   );

   // A pool count above the pool size acts as the pool size.
   assign eff_count    = (32'(count_ff) > 32'(POOL_SIZE)) ? CNT_W'(POOL_SIZE) : CNT_W'(count_ff);
   assign req_offset   = req_tdata - base_ff;
   assign req_in_range = req_offset < 32'(eff_count);
   // Pointer at or past the end restarts at zero.
   assign start_pos    = (32'(next_pos_ff) >= 32'(eff_count)) ? '0 : next_pos_ff;

   assign div_prod  = (POS_W+RECIP_W)'(pos_ff) * (POS_W+RECIP_W)'(RECIP_W'(RECIP));
   assign word_base = SUM_W'(quot_ff) * SUM_W'(WORD_BITS);
   assign hit_pos   = wpos_ff + SUM_W'(scan_bit);
   assign hit_next  = hit_pos + SUM_W'(1);
   assign off_mask  = {{(WORD_BITS-1){1'b0}}, 1'b1} << off_ff;
   assign hit_mask  = {{(WORD_BITS-1){1'b0}}, 1'b1} << scan_bit;
   assign cur_bit   = ram_rd_data[off_ff];

   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;

   always_comb begin
      state_in      = state_ff;
      base_in       = base_ff;
      count_in      = count_ff;
      in_order_in   = in_order_ff;
      next_pos_in   = next_pos_ff;
      leases_in     = leases_ff;
      clr_addr_in   = clr_addr_ff;
      func_in       = func_ff;
      pos_in        = pos_ff;
      quot_in       = quot_ff;
      word_in       = word_ff;
      wpos_in       = wpos_ff;
      off_in        = off_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      wrap_in       = wrap_ff;
      res_status_in = res_status_ff;
      res_value_in  = res_value_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_lease_in  = rsp_lease_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = word_ff;
      ram_wr_data   = ram_rd_data;

      // Take register writes in any state; software must write only while idle, which the block does not enforce.
      if (csr_valid) begin
         case (csr_index)
            CSR_BASE_VALUE: base_in     = csr_data;
            CSR_POOL_COUNT: count_in    = csr_data[COUNT_W-1:0];
            CSR_IN_ORDER:   in_order_in = csr_data[0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_CLEAR: begin
            // Zero one bitmap word per cycle after reset.
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_addr_ff;
            ram_wr_data = '0;
            clr_addr_in = clr_addr_ff + ADDR_W'(1);
            if (clr_addr_ff == ADDR_W'(NWORDS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               func_in       = req_tuser;
               res_status_in = 1'b1;
               res_value_in  = '0;
               state_in      = ST_FINISH;
               case (req_tuser)
                  FUNC_ALLOC: begin
                     next_pos_in = start_pos;
                     if (eff_count != '0) begin
                        pos_in   = start_pos;
                        lo_in    = SUM_W'(start_pos);
                        hi_in    = SUM_W'(eff_count);
                        wrap_in  = 1'b0;
                        state_in = ST_DIVIDE;
                     end
                  end
                  FUNC_RESERVE, FUNC_RELEASE: begin
                     if (req_in_range) begin
                        pos_in   = POS_W'(req_offset);
                        state_in = ST_DIVIDE;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_DIVIDE: begin
            quot_in  = POS_W'(div_prod >> DIV_S);
            state_in = ST_ISSUE;
         end
         ST_ISSUE: begin
            // Issue the first word read; data returns next cycle.
            word_in  = ADDR_W'(quot_ff);
            wpos_in  = word_base;
            off_in   = BIT_W'(SUM_W'(pos_ff) - word_base);
            state_in = (func_ff == FUNC_ALLOC) ? ST_SCAN : ST_MODIFY;
         end
         ST_SCAN: begin
            // Speculatively fetch the following word while this one is checked.
            word_in = scan_last ? '0 : word_ff + ADDR_W'(1);
            wpos_in = wpos_ff + SUM_W'(WORD_BITS);
            if (scan_hit) begin
               ram_wr_en     = 1'b1;
               ram_wr_data   = ram_rd_data | hit_mask;
               leases_in     = leases_ff + CNT_W'(1);
               res_status_in = 1'b0;
               res_value_in  = base_ff + VALUE_W'(hit_pos);
               if (!in_order_ff) begin
                  next_pos_in = (hit_next >= SUM_W'(POOL_SIZE)) ? '0 : POS_W'(hit_next);
               end
               state_in = ST_FINISH;
            end else if (scan_last) begin
               if (!wrap_ff && (lo_ff != '0)) begin
                  // Wrap: search from position zero up to the pointer.
                  wrap_in = 1'b1;
                  lo_in   = '0;
                  hi_in   = lo_ff;
                  wpos_in = '0;
               end else begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_MODIFY: begin
            if ((func_ff == FUNC_RESERVE) && !cur_bit) begin
               ram_wr_en     = 1'b1;
               ram_wr_data   = ram_rd_data | off_mask;
               leases_in     = leases_ff + CNT_W'(1);
               res_status_in = 1'b0;
            end else if ((func_ff == FUNC_RELEASE) && cur_bit) begin
               ram_wr_en     = 1'b1;
               ram_wr_data   = ram_rd_data & ~off_mask;
               leases_in     = (leases_ff != '0) ? leases_ff - CNT_W'(1) : leases_ff;
               res_status_in = 1'b0;
            end
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            // Hold the result until the output register is free.
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_value_in  = res_value_ff;
               rsp_lease_in  = COUNT_W'(leases_ff);
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         base_ff      <= '0;
         count_ff     <= COUNT_W'(POOL_SIZE);
         in_order_ff  <= 1'b0;
         next_pos_ff  <= '0;
         leases_ff    <= '0;
         clr_addr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         base_ff      <= base_in;
         count_ff     <= count_in;
         in_order_ff  <= in_order_in;
         next_pos_ff  <= next_pos_in;
         leases_ff    <= leases_in;
         clr_addr_ff  <= clr_addr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      func_ff       <= func_in;
      pos_ff        <= pos_in;
      quot_ff       <= quot_in;
      word_ff       <= word_in;
      wpos_ff       <= wpos_in;
      off_ff        <= off_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      wrap_ff       <= wrap_in;
      res_status_ff <= res_status_in;
      res_value_ff  <= res_value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_lease_ff  <= rsp_lease_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {{PAD_W{1'b0}}, rsp_lease_ff, rsp_value_ff};

   `BVPA_ASSERT_NEXT(a_one_in_flight, clock, reset, req_tvalid && req_tready,
      !req_tready, "request accepted while one is in flight")
   `BVPA_ASSERT_IMP(a_leases_bound, clock, reset, 1'b1,
      leases_ff <= CNT_W'(POOL_SIZE), "lease count above pool size")
   `BVPA_ASSERT_IMP(a_hit_in_window, clock, reset, (state_ff == ST_SCAN) && scan_hit,
      (hit_pos >= lo_ff) && (hit_pos < hi_ff), "allocated position outside search window")
   `BVPA_ASSERT_IMP(a_write_source, clock, reset, ram_wr_en,
      (state_ff == ST_CLEAR) || (state_ff == ST_SCAN) || (state_ff == ST_MODIFY),
      "bitmap write outside clear or update")

endmodule

`default_nettype wire

>>> tb/bitmap_value_pool_allocator_unit_tb.sv
`timescale 1ns / 1ps

module bitmap_value_pool_allocator_unit_tb;

   import bvpa_pkg::*;

   localparam int unsigned POOL_SIZE      = POOL_SIZE_DEF;
   localparam int unsigned WATCHDOG_LIMIT = 3000;
   localparam int unsigned RANDOM_ROUNDS  = 12;
   localparam int unsigned ROUND_ITEMS    = 120;
   localparam int unsigned FILL_COUNT     = 256;

   // Function code with no operation behind it; the block must reject it.
   localparam logic [FUNC_W-1:0] FUNC_UNKNOWN = 2'd3;

   // One response of the allocator, as the scoreboard sees it.
   typedef struct packed {
      logic               status;
      logic [VALUE_W-1:0] out_value;
      logic [COUNT_W-1:0] lease_count;
   } pool_reply_type;

   logic                 clock;
   logic                 reset;
   logic                 req_tvalid;
   logic                 req_tready;
   logic [VALUE_W-1:0]   req_tdata;   // [31:0] req_value
   logic [FUNC_W-1:0]    req_tuser;   // [1:0] func
   logic                 rsp_tvalid;
   logic                 rsp_tready;
   logic [47:0]          rsp_tdata;   // [31:0] out_value, [44:32] lease_count
   logic                 rsp_tuser;   // [0] status
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [VALUE_W-1:0]   csr_data;

   // Mirror of the allocator: used map, next-fit pointer, lease total, registers.
   bit                   pool_used [POOL_SIZE];
   int unsigned          fit_ptr;
   int unsigned          lease_total;
   logic [VALUE_W-1:0]   cfg_base;
   logic [COUNT_W-1:0]   cfg_count;
   logic                 cfg_in_order;

   pool_reply_type       pool_replies [$];
   int unsigned          errors;
   bit                   idle_on;
   int                   rsp_hold_len;

   bitmap_value_pool_allocator_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // 20 ns clock, low for the first half period.
   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // ------------------------------------------------------------------
   // Allocator mirror
   // ------------------------------------------------------------------

   // Pool size in effect: a count above the physical pool acts as the full pool.
   function automatic int unsigned pool_span();
      return (cfg_count > POOL_SIZE) ? POOL_SIZE : int'(cfg_count);
   endfunction

   // First clear position at or after the pointer, then wrap to position 0.
   function automatic int find_clear_pos(int unsigned from, int unsigned span);
      for (int unsigned p = from; p < span; p++)
         if (!pool_used[p]) return int'(p);
      for (int unsigned p = 0; p < from && p < span; p++)
         if (!pool_used[p]) return int'(p);
      return -1;
   endfunction

   // Apply one operation to the mirror and return the response it must produce.
   function automatic pool_reply_type apply_pool_op(logic [FUNC_W-1:0] func,
                                                    logic [VALUE_W-1:0] value);
      pool_reply_type     reply;
      int unsigned        span;
      int unsigned        pos;
      int                 found;
      logic [VALUE_W-1:0] offset;
      reply.status    = 1'b1;
      reply.out_value = '0;
      span            = pool_span();
      if (func == FUNC_ALLOC) begin
         // A pointer left beyond a shrunk pool restarts at zero.
         if (fit_ptr >= span) fit_ptr = 0;
         found = find_clear_pos(fit_ptr, span);
         if (found >= 0) begin
            pos             = found;
            pool_used[pos]  = 1'b1;
            lease_total++;
            reply.out_value = cfg_base + pos;
            reply.status    = 1'b0;
            if (!cfg_in_order) fit_ptr = (pos + 1 >= POOL_SIZE) ? 0 : pos + 1;
         end
      end else if (func == FUNC_RESERVE || func == FUNC_RELEASE) begin
         // Range check is modulo 2^32, so a pool may straddle the top of the range.
         offset = value - cfg_base;
         if (offset < span) begin
            if (func == FUNC_RESERVE && !pool_used[offset]) begin
               pool_used[offset] = 1'b1;
               lease_total++;
               reply.status = 1'b0;
            end else if (func == FUNC_RELEASE && pool_used[offset]) begin
               pool_used[offset] = 1'b0;
               if (lease_total > 0) lease_total--;
               reply.status = 1'b0;
            end
         end
      end
      reply.lease_count = lease_total[COUNT_W-1:0];
      return reply;
   endfunction

   task automatic clear_mirror();
      foreach (pool_used[p]) pool_used[p] = 1'b0;
      fit_ptr      = 0;
      lease_total  = 0;
      cfg_base     = '0;
      cfg_count    = COUNT_W'(POOL_SIZE);
      cfg_in_order = 1'b0;
   endtask

   function automatic void check_field(string name, logic [VALUE_W-1:0] want,
                                       logic [VALUE_W-1:0] got);
      if (want !== got) begin
         errors++;
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      end
   endfunction

   // ------------------------------------------------------------------
   // Scoreboard: check responses, then record register writes and requests
   // of the same edge. Only one request is in flight, so the oldest entry
   // always belongs to the response.
   // ------------------------------------------------------------------
   always @(posedge clock) begin : pool_scoreboard
      pool_reply_type want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (pool_replies.size() == 0) begin
               errors++;
               $display("%0t: response with nothing expected, expected none, actual %h/%h",
                        $time, rsp_tuser, rsp_tdata);
            end else begin
               want = pool_replies.pop_front();
               check_field("status", VALUE_W'(want.status), VALUE_W'(rsp_tuser));
               check_field("out_value", want.out_value, rsp_tdata[31:0]);
               check_field("lease_count", VALUE_W'(want.lease_count),
                           VALUE_W'(rsp_tdata[44:32]));
               check_field("tdata padding", '0, VALUE_W'(rsp_tdata[47:45]));
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_BASE_VALUE: cfg_base     = csr_data;
               CSR_POOL_COUNT: cfg_count    = csr_data[COUNT_W-1:0];
               CSR_IN_ORDER:   cfg_in_order = csr_data[0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) pool_replies.push_back(apply_pool_op(req_tuser, req_tdata));
      end
   end

   // ------------------------------------------------------------------
   // Response ready: random stalls while idle_on is set, plus a long hold-off counted
   // down here whenever a test loads rsp_hold_len.
   // ------------------------------------------------------------------
   initial begin : rsp_ready_driver
      int unsigned stall_left;
      stall_left = 0;
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_hold_len > 0) begin
            rsp_tready <= 1'b0;
            rsp_hold_len = rsp_hold_len - 1;
         end else if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            stall_left = $urandom_range(0, 2);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Abort when no transaction moves on any channel for too long.
   initial begin : watchdog
      int unsigned quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("[bitmap_value_pool_allocator_unit] ERROR");
      $finish;
   end

   // ------------------------------------------------------------------
   // Channel tasks
   // ------------------------------------------------------------------

   // Offer one request, optionally after a short gap, and hold it until taken.
   task automatic send_op(logic [FUNC_W-1:0] func, logic [VALUE_W-1:0] value);
      if (idle_on && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= func;
      req_tdata  <= value;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // Drop the request and wait until every response has been checked.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pool_replies.size() != 0) @(posedge clock);
   endtask

   task automatic write_csr(csr_index_type idx, logic [VALUE_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_pool(logic [VALUE_W-1:0] base, logic [COUNT_W-1:0] count, logic in_order);
      wait_drained();
      write_csr(CSR_BASE_VALUE, base);
      write_csr(CSR_POOL_COUNT, VALUE_W'(count));
      write_csr(CSR_IN_ORDER, VALUE_W'(in_order));
   endtask

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Every operation at the edges of the pool, with each corner case once.
   task automatic test_directed();
      // Reset settings: base 0, full pool, next-fit.
      send_op(FUNC_ALLOC, 32'hFFFF_FFFF);     // value 0, request value ignored
      send_op(FUNC_ALLOC, '0);                // value 1
      send_op(FUNC_RESERVE, '0);              // already used: fail
      send_op(FUNC_RELEASE, 32'd1);           // ok
      send_op(FUNC_RELEASE, 32'd1);           // already free: fail
      send_op(FUNC_RESERVE, 32'd4095);        // last position: ok
      send_op(FUNC_RESERVE, 32'd4096);        // one past the end: fail
      send_op(FUNC_RELEASE, 32'hFFFF_FFFF);   // out of range: fail
      send_op(FUNC_UNKNOWN, '0);              // rejected, nothing changes
      send_op(FUNC_ALLOC, '0);                // value 2, pointer to 3

      // Four-entry pool across the top of the value range, in-order search.
      set_pool(32'hFFFF_FFFE, 13'd4, 1'b1);
      send_op(FUNC_ALLOC, '0);                // position 3, wraps to value 1
      send_op(FUNC_ALLOC, '0);                // search wraps to position 1
      send_op(FUNC_ALLOC, '0);                // pool full: fail
      send_op(FUNC_RELEASE, 32'h0000_0000);   // position 2
      send_op(FUNC_ALLOC, '0);                // position 2 again, pointer holds
      send_op(FUNC_RESERVE, 32'hFFFF_FFFD);   // just below base: fail

      // Empty pool: everything fails.
      set_pool(32'hFFFF_FFFE, 13'd0, 1'b0);
      send_op(FUNC_ALLOC, '0);
      send_op(FUNC_RESERVE, 32'hFFFF_FFFE);
      send_op(FUNC_RELEASE, 32'hFFFF_FFFE);

      // Oversized count acts as the full pool.
      set_pool(32'h0, 13'h1FFF, 1'b0);
      send_op(FUNC_ALLOC, '0);                // position 4, pointer to 5
      send_op(FUNC_RELEASE, 32'd4095);

      // Shrink below the pointer: it restarts at zero.
      set_pool(32'h0, 13'd2, 1'b0);
      send_op(FUNC_ALLOC, '0);                // both used: fail
      send_op(FUNC_RELEASE, 32'd1);
      send_op(FUNC_ALLOC, '0);                // position 1
   endtask

   // Fill a pool that spans several words and the top of the value range, so
   // the pointer runs past its end; hit the full case, free a few holes for
   // the wrap search, then empty the pool.
   task automatic test_fill_wrap();
      logic [VALUE_W-1:0] base;
      base = 32'hFFFF_FF80;
      set_pool(base, COUNT_W'(FILL_COUNT), 1'b0);
      repeat (FILL_COUNT + 4) send_op(FUNC_ALLOC, $urandom);
      repeat (12) send_op(FUNC_RELEASE, base + $urandom_range(0, FILL_COUNT - 1));
      repeat (14) send_op(FUNC_ALLOC, $urandom);
      for (int unsigned p = 0; p < FILL_COUNT; p++) send_op(FUNC_RELEASE, base + p);
   endtask

   // Hold the response side off while requests keep coming, so the block
   // backs up into its input; then pause the sender until all is back.
   task automatic test_backpressure();
      set_pool($urandom, 13'd16, 1'b0);
      rsp_hold_len = 300;
      repeat (20) begin
         if ($urandom_range(0, 1) == 0)
            send_op(FUNC_ALLOC, $urandom);
         else
            send_op(FUNC_RELEASE, cfg_base + $urandom_range(0, 15));
      end
      wait_drained();
   endtask

   function automatic logic [VALUE_W-1:0] pick_base();
      case ($urandom_range(0, 3))
         0:       return '0;
         1:       return 32'hFFFF_FFFF - $urandom_range(0, 40);
         default: return $urandom;
      endcase
   endfunction

   // Rounds of random settings, each a burst of mostly well-formed traffic.
   task automatic test_random();
      logic [COUNT_W-1:0] count;
      int unsigned        span;
      int unsigned        pick;
      for (int unsigned round = 0; round < RANDOM_ROUNDS; round++) begin
         case (round)
            3:       count = COUNT_W'(POOL_SIZE);
            5:       count = '0;
            7:       count = COUNT_W'($urandom_range(POOL_SIZE + 1, 8191));
            default: count = COUNT_W'($urandom_range(1, 64));
         endcase
         set_pool(pick_base(), count, 1'($urandom_range(0, 1)));
         // Final round runs with no idling on either side.
         if (round == RANDOM_ROUNDS - 1) idle_on = 1'b0;
         span = pool_span();
         repeat (ROUND_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 40)
               send_op(FUNC_ALLOC, $urandom);
            else if (pick < 70 && span > 0)
               send_op(FUNC_RELEASE, cfg_base + $urandom_range(0, span - 1));
            else if (pick < 85 && span > 0)
               send_op(FUNC_RESERVE, cfg_base + $urandom_range(0, span - 1));
            else if (pick < 95)
               send_op($urandom_range(0, 1) ? FUNC_RESERVE : FUNC_RELEASE, $urandom);
            else
               send_op(FUNC_UNKNOWN, $urandom);
         end
      end
   endtask

   // ------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------
   initial begin : run_tests
      errors       = 0;
      idle_on      = 1'b1;
      rsp_hold_len = 0;
      clear_mirror();
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      req_tuser    = '0;
      csr_valid    = 1'b0;
      csr_index    = '0;
      csr_data     = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_directed();
      test_fill_wrap();
      test_backpressure();
      test_random();

      // Drain, then keep the clock running for any stray response.
      wait_drained();
      repeat (200) @(posedge clock);
      if (errors == 0)
         $display("[bitmap_value_pool_allocator_unit] OK");
      else
         $display("[bitmap_value_pool_allocator_unit] ERROR");
      $finish;
   end

endmodule

>>> bitmap_value_pool_allocator_unit.f
+incdir+rtl
rtl/bvpa_pkg.sv
rtl/bvpa_bitmap_ram.sv
rtl/bvpa_word_scan.sv
rtl/bitmap_value_pool_allocator_unit.sv
tb/bitmap_value_pool_allocator_unit_tb.sv
